// ===== src/bmhq_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bmhq_pkg
// Shared sizes, codes, entry type and the controller/datapath interface
// for the binary max-heap priority queue.
// ----------------------------------------------------------------------------
package bmhq_pkg;

    // heap geometry
    localparam int HEAP_DEPTH = 64;
    localparam int TAG_BITS   = 16;
    localparam int ADDR_W     = $clog2(HEAP_DEPTH);
    localparam int CNT_W      = $clog2(HEAP_DEPTH + 1);
    localparam int CHILD_W    = ADDR_W + 2;

    // port field widths
    localparam int KEY_W      = 16;
    localparam int TAG_IO_W   = 16;
    localparam int STATUS_W   = 2;
    localparam int OCC_W      = 7;
    localparam int IN_DATA_W  = 32;
    localparam int OUT_DATA_W = 48;
    localparam int OUT_USED_W = KEY_W + TAG_IO_W + STATUS_W + OCC_W;

    // operation kinds
    localparam logic KIND_INSERT  = 1'b0;
    localparam logic KIND_EXTRACT = 1'b1;

    // result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    // one heap slot
    typedef struct packed {
        logic [KEY_W-1:0]    key;
        logic [TAG_BITS-1:0] tag;
    } t_entry;

    // phase commands from the controller
    typedef struct packed {
        logic accept;
        logic up_rd;
        logic up_cmp;
        logic dn_start;
        logic dn_load;
        logic dn_rd;
        logic dn_cmp;
        logic out_load;
    } t_ctl;

    // decisions reported by the datapath
    typedef struct packed {
        logic kind;
        logic full;
        logic empty;
        logic last_one;
        logic pos_zero;
        logic up_move;
        logic dn_move;
    } t_sts;

endpackage : bmhq_pkg
`default_nettype wire

// ===== src/bmhq_datapath.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bmhq_datapath
// Heap memory, item count, moving-item register, sift compare logic and
// the output register of the priority queue.
// ----------------------------------------------------------------------------
module bmhq_datapath (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire bmhq_pkg::t_ctl                  i_ctl,
    output bmhq_pkg::t_sts                       o_sts,
    input  wire logic                            i_kind,
    input  wire logic [bmhq_pkg::KEY_W-1:0]      i_key,
    input  wire logic [bmhq_pkg::TAG_IO_W-1:0]   i_tag,
    output logic      [bmhq_pkg::OUT_DATA_W-1:0] o_data
);
    import bmhq_pkg::*;

    // heap storage and registered read ports
    t_entry r_mem [HEAP_DEPTH];
    t_entry r_rd_a;
    t_entry r_rd_b;

    logic [CNT_W-1:0]    r_count;
    logic [ADDR_W-1:0]   r_pos;
    t_entry              r_item;
    logic [KEY_W-1:0]    r_res_key;
    logic [TAG_BITS-1:0] r_res_tag;
    t_status             r_res_status;

    logic [KEY_W-1:0]    r_out_key;
    logic [TAG_IO_W-1:0] r_out_tag;
    t_status             r_out_status;
    logic [OCC_W-1:0]    r_out_occ;

    logic [ADDR_W-1:0]   rd_addr_a;
    logic [ADDR_W-1:0]   rd_addr_b;
    logic                wr_en;
    t_entry              wr_data;

    logic [ADDR_W-1:0]   parent;
    logic [CHILD_W-1:0]  child_l;
    logic [CHILD_W-1:0]  child_r;
    logic                l_ok;
    logic                r_ok;
    logic                take_l;
    logic                take_r;
    logic [KEY_W-1:0]    best_key;
    logic                full;
    logic                empty;

    // neighbor indexes of the hole
    always_comb begin
        parent  = ADDR_W'((r_pos - ADDR_W'(1)) >> 1);
        child_l = CHILD_W'({r_pos, 1'b0}) + CHILD_W'(1);
        child_r = CHILD_W'({r_pos, 1'b0}) + CHILD_W'(2);
        l_ok    = child_l < CHILD_W'(r_count);
        r_ok    = child_r < CHILD_W'(r_count);
        full    = r_count >= CNT_W'(HEAP_DEPTH);
        empty   = r_count == '0;
    end

    // pick the larger child; the left one wins a tie, an equal key stays put
    always_comb begin
        take_l   = l_ok && (r_rd_a.key > r_item.key);
        best_key = take_l ? r_rd_a.key : r_item.key;
        take_r   = r_ok && (r_rd_b.key > best_key);
    end

    // status to the controller
    always_comb begin
        o_sts.kind     = i_kind;
        o_sts.full     = full;
        o_sts.empty    = empty;
        o_sts.last_one = r_count == CNT_W'(1);
        o_sts.pos_zero = r_pos == '0;
        o_sts.up_move  = r_rd_a.key < r_item.key;
        o_sts.dn_move  = take_l || take_r;
    end

    // read addresses and write port
    always_comb begin
        rd_addr_a = '0;
        rd_addr_b = '0;
        wr_en     = 1'b0;
        wr_data   = r_item;
        if (i_ctl.up_rd) begin
            rd_addr_a = parent;
            wr_en     = o_sts.pos_zero;
        end
        if (i_ctl.up_cmp) begin
            wr_en   = 1'b1;
            wr_data = o_sts.up_move ? r_rd_a : r_item;
        end
        if (i_ctl.dn_start) begin
            rd_addr_b = ADDR_W'(r_count - CNT_W'(1));
        end
        if (i_ctl.dn_rd) begin
            rd_addr_a = child_l[ADDR_W-1:0];
            rd_addr_b = child_r[ADDR_W-1:0];
        end
        if (i_ctl.dn_cmp) begin
            wr_en = 1'b1;
            if (take_r) begin
                wr_data = r_rd_b;
            end else if (take_l) begin
                wr_data = r_rd_a;
            end
        end
    end

    // heap memory
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_pos] <= wr_data;
        end
        r_rd_a <= r_mem[rd_addr_a];
        r_rd_b <= r_mem[rd_addr_b];
    end

    // item count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_ctl.accept && i_kind == KIND_INSERT && !full) begin
            r_count <= r_count + CNT_W'(1);
        end else if (i_ctl.dn_load) begin
            r_count <= r_count - CNT_W'(1);
        end
    end

    // moving item, hole position and pending result
    always_ff @(posedge i_clk) begin
        if (i_ctl.accept) begin
            r_item.key <= i_key;
            r_item.tag <= TAG_BITS'(i_tag);
            r_pos      <= ADDR_W'(r_count);
            r_res_key  <= '0;
            r_res_tag  <= '0;
            if (i_kind == KIND_INSERT && full) begin
                r_res_status <= ST_FULL;
            end else if (i_kind == KIND_EXTRACT && empty) begin
                r_res_status <= ST_EMPTY;
            end else begin
                r_res_status <= ST_OK;
            end
        end
        if (i_ctl.up_cmp && o_sts.up_move) begin
            r_pos <= parent;
        end
        if (i_ctl.dn_load) begin
            r_res_key <= r_rd_a.key;
            r_res_tag <= r_rd_a.tag;
            r_item    <= r_rd_b;
            r_pos     <= '0;
        end
        if (i_ctl.dn_cmp) begin
            if (take_r) begin
                r_pos <= child_r[ADDR_W-1:0];
            end else if (take_l) begin
                r_pos <= child_l[ADDR_W-1:0];
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (i_ctl.out_load) begin
            r_out_key    <= r_res_key;
            r_out_tag    <= TAG_IO_W'(r_res_tag);
            r_out_status <= r_res_status;
            r_out_occ    <= OCC_W'(r_count);
        end
    end

    assign o_data = OUT_DATA_W'({r_out_occ, r_out_status, r_out_tag, r_out_key});

endmodule : bmhq_datapath
`default_nettype wire

// ===== src/bmhq_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bmhq_ctrl
// Sequencer of the priority queue: accepts one operation, steps the sift
// up or down one level per read and compare state pair and hands the result
// to the output register.
// ----------------------------------------------------------------------------
module bmhq_ctrl (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_s_tvalid,
    output logic                o_s_tready,
    output logic                o_m_tvalid,
    input  wire logic           i_m_tready,
    input  wire bmhq_pkg::t_sts i_sts,
    output bmhq_pkg::t_ctl      o_ctl
);
    import bmhq_pkg::*;

    typedef enum logic [7:0] {
        S_IDLE     = 8'b0000_0001,
        S_UP_RD    = 8'b0000_0010,
        S_UP_CMP   = 8'b0000_0100,
        S_DN_START = 8'b0000_1000,
        S_DN_LOAD  = 8'b0001_0000,
        S_DN_RD    = 8'b0010_0000,
        S_DN_CMP   = 8'b0100_0000,
        S_FINISH   = 8'b1000_0000
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_m_valid;
    logic   n_m_valid;
    logic   accept;
    logic   out_free;

    assign o_s_tready = r_state == S_IDLE;
    assign o_m_tvalid = r_m_valid;
    assign accept     = i_s_tvalid && o_s_tready;
    assign out_free   = !r_m_valid || i_m_tready;

    // next state and phase commands
    always_comb begin
        n_state = r_state;
        o_ctl   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    o_ctl.accept = 1'b1;
                    if (i_sts.kind == KIND_INSERT && !i_sts.full) begin
                        n_state = S_UP_RD;
                    end else if (i_sts.kind == KIND_EXTRACT && !i_sts.empty) begin
                        n_state = S_DN_START;
                    end else begin
                        n_state = S_FINISH;
                    end
                end
            end
            S_UP_RD: begin
                o_ctl.up_rd = 1'b1;
                n_state     = i_sts.pos_zero ? S_FINISH : S_UP_CMP;
            end
            S_UP_CMP: begin
                o_ctl.up_cmp = 1'b1;
                n_state      = i_sts.up_move ? S_UP_RD : S_FINISH;
            end
            S_DN_START: begin
                o_ctl.dn_start = 1'b1;
                n_state        = S_DN_LOAD;
            end
            S_DN_LOAD: begin
                o_ctl.dn_load = 1'b1;
                n_state       = i_sts.last_one ? S_FINISH : S_DN_RD;
            end
            S_DN_RD: begin
                o_ctl.dn_rd = 1'b1;
                n_state     = S_DN_CMP;
            end
            S_DN_CMP: begin
                o_ctl.dn_cmp = 1'b1;
                n_state      = i_sts.dn_move ? S_DN_RD : S_FINISH;
            end
            S_FINISH: begin
                if (out_free) begin
                    o_ctl.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // output valid: set on load, drop when taken
    always_comb begin
        n_m_valid = r_m_valid;
        if (r_m_valid && i_m_tready) begin
            n_m_valid = 1'b0;
        end
        if (o_ctl.out_load) begin
            n_m_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_m_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_m_valid <= n_m_valid;
        end
    end

endmodule : bmhq_ctrl
`default_nettype wire

// ===== src/binary_max_heap_queue_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// binary_max_heap_queue_top
// Binary max-heap priority queue of keyed, tagged items with insert and
// extract-maximum operations over stream channels.
// ----------------------------------------------------------------------------
// Sequence: a dropped insert or empty extract goes straight to the finish
// state; an insert reads and compares one parent per level up to the root;
// an extract takes the root and last item, then one read and compare per level.
// Throughput: one operation at a time, the next accepted the cycle after the
// result loads; a held result stalls the input.
// Reset: synchronous, active low; the heap comes up empty, memory not cleared.
module binary_max_heap_queue_top (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    // operation in
    input  wire logic                            i_s_tvalid,
    output logic                                 o_s_tready,
    input  wire logic [bmhq_pkg::IN_DATA_W-1:0]  i_s_tdata,  // key[15:0], tag[31:16]
    input  wire logic                            i_s_tuser,  // kind
    // result out
    output logic                                 o_m_tvalid,
    input  wire logic                            i_m_tready,
    output logic      [bmhq_pkg::OUT_DATA_W-1:0] o_m_tdata   // out_key[15:0], out_tag[31:16],
                                                             // status[33:32], occupancy[40:34]
);
    import bmhq_pkg::*;

    t_ctl ctl;
    t_sts sts;

    // sequencer
    bmhq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .i_sts      (sts),
        .o_ctl      (ctl)
    );

    // heap memory and compare logic
    bmhq_datapath u_datapath (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (ctl),
        .o_sts   (sts),
        .i_kind  (i_s_tuser),
        .i_key   (i_s_tdata[KEY_W-1:0]),
        .i_tag   (i_s_tdata[KEY_W+TAG_IO_W-1:KEY_W]),
        .o_data  (o_m_tdata)
    );

endmodule : binary_max_heap_queue_top
`default_nettype wire
